// File: rtl/id3p_pkg.sv
// Package for the ID3v2 tag stream parser: parse phases, result kinds,
// the result record and the sizing constants. No dependencies.
package id3p_pkg;

    typedef enum logic [3:0] {
        PH_SIG  = 4'd0,
        PH_VER  = 4'd1,
        PH_FLG  = 4'd2,
        PH_TSZ  = 4'd3,
        PH_FID  = 4'd4,
        PH_FSZ  = 4'd5,
        PH_FFL  = 4'd6,
        PH_PAY  = 4'd7,
        PH_DONE = 4'd8,
        PH_ERR  = 4'd9
    } t_phase;

    localparam logic [2:0] K_TAG     = 3'd0;
    localparam logic [2:0] K_FRAME   = 3'd1;
    localparam logic [2:0] K_PAYLOAD = 3'd2;
    localparam logic [2:0] K_END     = 3'd3;
    localparam logic [2:0] K_BADSIG  = 3'd4;

    localparam logic [7:0]  SIG_CHAR0 = 8'h49;
    localparam logic [7:0]  SIG_CHAR1 = 8'h44;
    localparam logic [7:0]  SIG_CHAR2 = 8'h33;
    localparam logic [6:0]  SYNC_MASK = 7'h7F;
    localparam logic [29:0] HDR_BYTES = 30'd10;
    localparam logic [28:0] CONS_MAX  = 29'h1FFF_FFFF;

    // Output queue depth; the parser needs room for two results per item.
    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_AW    = $clog2(Q_DEPTH);

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] frame_id;
        logic [27:0] size_value;
        logic [15:0] flag_bits;
        logic [15:0] version;
        logic [7:0]  payload_byte;
        logic        last_in_frame;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_emit;

    function automatic t_result mk_result(
        input logic [2:0]  kind,
        input logic [31:0] frame_id,
        input logic [27:0] size_value,
        input logic [15:0] flag_bits,
        input logic [15:0] version,
        input logic [7:0]  payload_byte,
        input logic        last_in_frame
    );
        t_result r;
        r.kind          = kind;
        r.frame_id      = frame_id;
        r.size_value    = size_value;
        r.flag_bits     = flag_bits;
        r.version       = version;
        r.payload_byte  = payload_byte;
        r.last_in_frame = last_in_frame;
        return r;
    endfunction

endpackage

// File: rtl/id3p_if.sv
// Stream channel interfaces for the ID3v2 tag stream parser: raw input
// bytes and parse results. No dependencies.
interface id3p_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       start_of_stream;

    modport source (output valid, output in_byte, output start_of_stream, input ready);
    modport sink   (input valid, input in_byte, input start_of_stream, output ready);
endinterface

interface id3p_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [31:0] frame_id;
    logic [27:0] size_value;
    logic [15:0] flag_bits;
    logic [15:0] version;
    logic [7:0]  payload_byte;
    logic        last_in_frame;

    modport source (
        output valid, output kind, output frame_id, output size_value,
        output flag_bits, output version, output payload_byte,
        output last_in_frame, input ready
    );
    modport sink (
        input valid, input kind, input frame_id, input size_value,
        input flag_bits, input version, input payload_byte,
        input last_in_frame, output ready
    );
endinterface

// File: rtl/id3v2_tag_stream_parser.sv
// Top level of the ID3v2 tag stream parser: parse core and result queue.
// Depends on id3p_pkg, id3p_if, id3p_parse_core and id3p_out_queue.
//
// Usage: feed the file one byte per item on i_in, from offset 0, with
// start_of_stream set on the first byte of every file. The block checks
// the "ID3" signature, then reports one tag header result (version, flags,
// decoded syncsafe tag size), one frame header result per frame, one
// payload result per frame value byte after the encoding byte (the last
// one marked), and a tag end result. A signature mismatch gives a single
// bad signature result; later bytes are then taken and dropped until the
// next start_of_stream. Fields that do not belong to a result kind are 0.
//
// Throughput is one byte per cycle while i_in.ready is high. A byte's
// results are written into a four-entry result queue at the edge that
// accepts it, and o_out shows them in order after any results already
// queued; a second one is a tag end. One byte yields at most two results,
// so i_in.ready drops while the queue holds more than two; a stalled
// receiver therefore stops input before the queue overflows and nothing
// is lost. o_out holds its item steady until taken. Synchronous reset
// empties the queue and returns the parse to waiting for the signature.
module id3v2_tag_stream_parser
    import id3p_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    id3p_in_if.sink      i_in,
    id3p_out_if.source   o_out
);

    t_emit   w_emit;
    t_result w_head;
    logic    w_room;
    logic    w_accept;

    assign i_in.ready = w_room;
    assign w_accept   = i_in.valid && w_room;

    id3p_parse_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (w_accept),
        .i_in_byte (i_in.in_byte),
        .i_start   (i_in.start_of_stream),
        .o_emit    (w_emit)
    );

    id3p_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_emit  (w_emit),
        .i_pop   (o_out.ready),
        .o_room  (w_room),
        .o_valid (o_out.valid),
        .o_head  (w_head)
    );

    assign o_out.kind          = w_head.kind;
    assign o_out.frame_id      = w_head.frame_id;
    assign o_out.size_value    = w_head.size_value;
    assign o_out.flag_bits     = w_head.flag_bits;
    assign o_out.version       = w_head.version;
    assign o_out.payload_byte  = w_head.payload_byte;
    assign o_out.last_in_frame = w_head.last_in_frame;

endmodule

// File: rtl/id3p_parse_core.sv
// Parse state registers and the per-byte next-state logic of the ID3v2
// tag stream parser. Depends on id3p_pkg.
module id3p_parse_core
    import id3p_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_in_byte,
    input  logic       i_start,
    output t_emit      o_emit
);

    t_phase      r_phase, n_phase, e_phase;
    logic [2:0]  r_cnt, n_cnt, e_cnt;
    logic [27:0] r_tag_size, n_tag_size, e_tag_size;
    logic [28:0] r_consumed, n_consumed, e_consumed;
    logic [31:0] r_id, n_id, e_id;
    logic [27:0] r_fsize, n_fsize, e_fsize;
    logic [27:0] r_remain, n_remain, e_remain;
    logic [15:0] r_ver, n_ver, e_ver;
    logic [7:0]  r_hflags, n_hflags, e_hflags;
    logic [15:0] r_fflags, n_fflags, e_fflags;

    // A start byte sees the cleared state, as if the parse began here.
    assign e_phase    = i_start ? PH_SIG : r_phase;
    assign e_cnt      = i_start ? '0 : r_cnt;
    assign e_tag_size = i_start ? '0 : r_tag_size;
    assign e_consumed = i_start ? '0 : r_consumed;
    assign e_id       = i_start ? '0 : r_id;
    assign e_fsize    = i_start ? '0 : r_fsize;
    assign e_remain   = i_start ? '0 : r_remain;
    assign e_ver      = i_start ? '0 : r_ver;
    assign e_hflags   = i_start ? '0 : r_hflags;
    assign e_fflags   = i_start ? '0 : r_fflags;

    logic [2:0]  w_cnt_inc;
    logic [7:0]  w_sig_char;
    logic        w_bad_sig;
    logic [27:0] w_tsz_new;
    logic [27:0] w_fsz_new;
    logic [15:0] w_fflags_new;
    logic        w_fid_zero;
    logic [29:0] w_sum;
    logic [28:0] w_cons_new;
    logic        w_tag_end;
    logic        w_first;
    logic [27:0] w_remain_dec;
    logic        w_pay_last;

    assign w_cnt_inc = e_cnt + 3'd1;

    always_comb begin
        unique case (e_cnt)
            3'd0:    w_sig_char = SIG_CHAR0;
            3'd1:    w_sig_char = SIG_CHAR1;
            default: w_sig_char = SIG_CHAR2;
        endcase
    end

    assign w_bad_sig    = (e_cnt > 3'd2) || (i_in_byte != w_sig_char);
    assign w_tsz_new    = {e_tag_size[20:0], i_in_byte[6:0] & SYNC_MASK};
    assign w_fsz_new    = {e_fsize[20:0], i_in_byte[6:0] & SYNC_MASK};
    assign w_fflags_new = {e_fflags[7:0], i_in_byte};
    assign w_fid_zero   = (e_cnt == 3'd0) && (i_in_byte == 8'd0);

    // Frame end bookkeeping: header plus frame size, saturating.
    assign w_sum      = {1'b0, e_consumed} + {2'b00, e_fsize} + HDR_BYTES;
    assign w_cons_new = (w_sum > {1'b0, CONS_MAX}) ? CONS_MAX : w_sum[28:0];
    assign w_tag_end  = w_cons_new >= {1'b0, e_tag_size};

    assign w_first      = (e_remain == e_fsize);
    assign w_remain_dec = (e_remain != '0) ? (e_remain - 28'd1) : '0;
    assign w_pay_last   = (w_remain_dec == '0);

    // Next parse phase.
    always_comb begin
        n_phase = r_phase;
        if (i_accept) begin
            n_phase = e_phase;
            unique case (e_phase)
                PH_SIG: begin
                    if (w_bad_sig) begin
                        n_phase = PH_ERR;
                    end else if (w_cnt_inc == 3'd3) begin
                        n_phase = PH_VER;
                    end
                end
                PH_VER: begin
                    if (w_cnt_inc >= 3'd2) begin
                        n_phase = PH_FLG;
                    end
                end
                PH_FLG: begin
                    n_phase = PH_TSZ;
                end
                PH_TSZ: begin
                    if (w_cnt_inc >= 3'd4) begin
                        n_phase = (w_tsz_new == '0) ? PH_DONE : PH_FID;
                    end
                end
                PH_FID: begin
                    if (w_fid_zero) begin
                        n_phase = PH_DONE;
                    end else if (w_cnt_inc >= 3'd4) begin
                        n_phase = PH_FSZ;
                    end
                end
                PH_FSZ: begin
                    if (w_cnt_inc >= 3'd4) begin
                        n_phase = PH_FFL;
                    end
                end
                PH_FFL: begin
                    if (w_cnt_inc >= 3'd2) begin
                        if (e_fsize != '0) begin
                            n_phase = PH_PAY;
                        end else begin
                            n_phase = w_tag_end ? PH_DONE : PH_FID;
                        end
                    end
                end
                PH_PAY: begin
                    if (w_pay_last) begin
                        n_phase = w_tag_end ? PH_DONE : PH_FID;
                    end
                end
                PH_DONE, PH_ERR: begin
                    n_phase = e_phase;
                end
                default: begin
                    n_phase = e_phase;
                end
            endcase
        end
    end

    // Field registers and the results of the accepted byte.
    always_comb begin
        n_cnt      = r_cnt;
        n_tag_size = r_tag_size;
        n_consumed = r_consumed;
        n_id       = r_id;
        n_fsize    = r_fsize;
        n_remain   = r_remain;
        n_ver      = r_ver;
        n_hflags   = r_hflags;
        n_fflags   = r_fflags;
        o_emit     = '0;
        if (i_accept) begin
            n_cnt      = e_cnt;
            n_tag_size = e_tag_size;
            n_consumed = e_consumed;
            n_id       = e_id;
            n_fsize    = e_fsize;
            n_remain   = e_remain;
            n_ver      = e_ver;
            n_hflags   = e_hflags;
            n_fflags   = e_fflags;
            unique case (e_phase)
                PH_SIG: begin
                    if (w_bad_sig) begin
                        o_emit.count = 2'd1;
                        o_emit.res0  = mk_result(K_BADSIG, '0, '0, '0, '0, '0, 1'b0);
                    end else begin
                        n_cnt = (w_cnt_inc == 3'd3) ? 3'd0 : w_cnt_inc;
                    end
                end
                PH_VER: begin
                    n_ver = {e_ver[7:0], i_in_byte};
                    n_cnt = (w_cnt_inc >= 3'd2) ? 3'd0 : w_cnt_inc;
                end
                PH_FLG: begin
                    n_hflags   = i_in_byte;
                    n_cnt      = '0;
                    n_tag_size = '0;
                end
                PH_TSZ: begin
                    n_tag_size = w_tsz_new;
                    n_cnt      = w_cnt_inc;
                    if (w_cnt_inc >= 3'd4) begin
                        n_cnt        = '0;
                        n_consumed   = '0;
                        n_id         = '0;
                        o_emit.count = 2'd1;
                        o_emit.res0  = mk_result(K_TAG, '0, w_tsz_new,
                                                 {8'h00, e_hflags}, e_ver, '0, 1'b0);
                        if (w_tsz_new == '0) begin
                            o_emit.count = 2'd2;
                            o_emit.res1  = mk_result(K_END, '0, '0, '0, '0, '0, 1'b0);
                        end
                    end
                end
                PH_FID: begin
                    if (w_fid_zero) begin
                        o_emit.count = 2'd1;
                        o_emit.res0  = mk_result(K_END, '0, '0, '0, '0, '0, 1'b0);
                    end else begin
                        n_id  = {e_id[23:0], i_in_byte};
                        n_cnt = w_cnt_inc;
                        if (w_cnt_inc >= 3'd4) begin
                            n_cnt   = '0;
                            n_fsize = '0;
                        end
                    end
                end
                PH_FSZ: begin
                    n_fsize = w_fsz_new;
                    n_cnt   = w_cnt_inc;
                    if (w_cnt_inc >= 3'd4) begin
                        n_cnt    = '0;
                        n_fflags = '0;
                    end
                end
                PH_FFL: begin
                    n_fflags = w_fflags_new;
                    n_cnt    = w_cnt_inc;
                    if (w_cnt_inc >= 3'd2) begin
                        n_cnt        = '0;
                        n_remain     = e_fsize;
                        o_emit.count = 2'd1;
                        o_emit.res0  = mk_result(K_FRAME, e_id, e_fsize, w_fflags_new,
                                                 '0, '0, 1'b0);
                        if (e_fsize == '0) begin
                            n_consumed = w_cons_new;
                            if (w_tag_end) begin
                                o_emit.count = 2'd2;
                                o_emit.res1  = mk_result(K_END, '0, '0, '0, '0, '0, 1'b0);
                            end else begin
                                n_id = '0;
                            end
                        end
                    end
                end
                PH_PAY: begin
                    n_remain = w_remain_dec;
                    if (!w_first) begin
                        o_emit.count = 2'd1;
                        o_emit.res0  = mk_result(K_PAYLOAD, e_id, '0, '0, '0,
                                                 i_in_byte, w_pay_last);
                    end
                    if (w_pay_last) begin
                        n_consumed = w_cons_new;
                        if (w_tag_end) begin
                            if (w_first) begin
                                o_emit.count = 2'd1;
                                o_emit.res0  = mk_result(K_END, '0, '0, '0, '0, '0, 1'b0);
                            end else begin
                                o_emit.count = 2'd2;
                                o_emit.res1  = mk_result(K_END, '0, '0, '0, '0, '0, 1'b0);
                            end
                        end else begin
                            n_cnt = '0;
                            n_id  = '0;
                        end
                    end
                end
                PH_DONE, PH_ERR: begin
                    o_emit.count = 2'd0;
                end
                default: begin
                    o_emit.count = 2'd0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_SIG;
            r_cnt      <= '0;
            r_tag_size <= '0;
            r_consumed <= '0;
            r_id       <= '0;
            r_fsize    <= '0;
            r_remain   <= '0;
            r_ver      <= '0;
            r_hflags   <= '0;
            r_fflags   <= '0;
        end else begin
            r_phase    <= n_phase;
            r_cnt      <= n_cnt;
            r_tag_size <= n_tag_size;
            r_consumed <= n_consumed;
            r_id       <= n_id;
            r_fsize    <= n_fsize;
            r_remain   <= n_remain;
            r_ver      <= n_ver;
            r_hflags   <= n_hflags;
            r_fflags   <= n_fflags;
        end
    end

endmodule

// File: rtl/id3p_out_queue.sv
// Small result queue of the ID3v2 tag stream parser: takes up to two
// results per cycle and hands out one. Depends on id3p_pkg.
module id3p_out_queue
    import id3p_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_emit   i_emit,
    input  logic    i_pop,
    output logic    o_room,
    output logic    o_valid,
    output t_result o_head
);

    t_result         r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [Q_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [Q_AW:0]   r_count, n_count;
    logic [Q_AW-1:0] w_wr_next;
    logic            w_pop;

    assign o_valid   = (r_count != '0);
    assign o_head    = r_mem[r_rd_ptr];
    // Room for the worst case of two results from the next item.
    assign o_room    = (r_count <= (Q_AW + 1)'(Q_DEPTH - 2));
    assign w_pop     = i_pop && o_valid;
    assign w_wr_next = r_wr_ptr + Q_AW'(1);

    assign n_wr_ptr = r_wr_ptr + Q_AW'(i_emit.count);
    assign n_rd_ptr = w_pop ? (r_rd_ptr + Q_AW'(1)) : r_rd_ptr;
    assign n_count  = r_count + (Q_AW + 1)'(i_emit.count) - (Q_AW + 1)'(w_pop);

    always_ff @(posedge i_clk) begin
        if (i_emit.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_emit.res0;
        end
        if (i_emit.count == 2'd2) begin
            r_mem[w_wr_next] <= i_emit.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// File: rtl/id3p_checker.sv
// Port-level checks for the ID3v2 tag stream parser and the bind that
// attaches them to the top level. Depends on id3p_pkg.
module id3p_checker
    import id3p_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  i_kind,
    input logic [31:0] i_frame_id,
    input logic [15:0] i_version,
    input logic [7:0]  i_payload_byte,
    input logic        i_last_in_frame
);

    // A waiting result is neither dropped nor changed in kind, frame id or payload byte.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_kind)
            && $stable(i_frame_id) && $stable(i_payload_byte))
        else $error("result changed while stalled");

    // Only payload results carry a byte or an end-of-frame mark.
    a_payload_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_kind != K_PAYLOAD |-> i_payload_byte == 8'd0
            && !i_last_in_frame)
        else $error("payload fields set on a non-payload result");

    // Frame headers carry no version; tag headers and ends carry no id.
    a_frame_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_kind == K_TAG || i_kind == K_END || i_kind == K_BADSIG)
            |-> i_frame_id == 32'd0)
        else $error("frame id set on a tag-level result");

    a_frame_ver: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_kind == K_FRAME |-> i_version == 16'd0)
        else $error("version set on a frame header");

    // Reset empties the result queue.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result shown right after reset");

endmodule

bind id3v2_tag_stream_parser id3p_checker u_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_kind          (o_out.kind),
    .i_frame_id      (o_out.frame_id),
    .i_version       (o_out.version),
    .i_payload_byte  (o_out.payload_byte),
    .i_last_in_frame (o_out.last_in_frame)
);
